[sv/rmq_pkg.sv]
// Shared widths, lane types and pivot selection codes for the
// rotation-matrix-to-quaternion pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int NUM_W     = IN_W + 1;
   localparam int RAD_W     = IN_W + 1;
   localparam int CALC_W    = IN_W + 3;
   localparam int SQ_IN_W   = 2 * ((RAD_W + FRAC_BITS + 1) / 2);
   localparam int SQ_STEPS  = SQ_IN_W / 2;
   localparam int ROOT_W    = SQ_STEPS;
   localparam int SQ_REM_W  = ROOT_W + 4;
   localparam int DVD_W     = NUM_W + FRAC_BITS;
   localparam int DIV_W     = ROOT_W + 1;
   localparam int DREM_W    = DIV_W + 1;
   localparam int DIV_STEPS = DVD_W;
   localparam int PIV_W     = ROOT_W;
   localparam logic [IN_W-1:0] ONE_Q = IN_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      SEL_X = 2'd0,
      SEL_Y = 2'd1,
      SEL_Z = 2'd2,
      SEL_W = 2'd3
   } sel_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
      logic [SQ_IN_W-1:0]  rad;
   } sq_lane_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [DIV_W-1:0]  dvsr;
      logic [DVD_W-1:0]  dvd;
      logic [DVD_W-1:0]  quo;
   } dv_lane_type;

   typedef struct packed {
      sel_type                  sel;
      logic signed [NUM_W-1:0]  n0;
      logic signed [NUM_W-1:0]  n1;
      logic signed [NUM_W-1:0]  n2;
   } sq_side_type;

   typedef struct packed {
      sel_type          sel;
      logic [2:0]       neg;
      logic [PIV_W-1:0] pivot;
   } dv_side_type;

endpackage
`default_nettype wire

[sv/rmq_sqrt_cell.sv]
// One digit step of the restoring square root: two radicand bits in, one root bit out.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell (
   input  wire                 clock,
   input  wire                 en,
   input  rmq_pkg::sq_lane_type lane_i,
   output rmq_pkg::sq_lane_type lane_o
);
   import rmq_pkg::*;

   logic [SQ_REM_W-1:0] rem_sh;
   logic [SQ_REM_W-1:0] trial;
   sq_lane_type         lane_ff;
   sq_lane_type         lane_in;

   always_comb begin
      rem_sh = {lane_i.rem[SQ_REM_W-3:0], lane_i.rad[SQ_IN_W-1 -: 2]};
      trial  = {{(SQ_REM_W-ROOT_W-2){1'b0}}, lane_i.root, 2'b01};
      lane_in.rad = {lane_i.rad[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         lane_in.rem  = rem_sh - trial;
         lane_in.root = {lane_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         lane_in.rem  = rem_sh;
         lane_in.root = {lane_i.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

[sv/rmq_div_cell.sv]
// One bit step of the restoring divider: one dividend bit in, one quotient bit out.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell (
   input  wire                 clock,
   input  wire                 en,
   input  rmq_pkg::dv_lane_type lane_i,
   output rmq_pkg::dv_lane_type lane_o
);
   import rmq_pkg::*;

   logic [DREM_W-1:0] rem_sh;
   logic [DREM_W-1:0] dvsr_x;
   dv_lane_type       lane_ff;
   dv_lane_type       lane_in;

   always_comb begin
      rem_sh = {lane_i.rem[DREM_W-2:0], lane_i.dvd[DVD_W-1]};
      dvsr_x = {1'b0, lane_i.dvsr};
      lane_in.dvsr = lane_i.dvsr;
      lane_in.dvd  = {lane_i.dvd[DVD_W-2:0], 1'b0};
      if (rem_sh >= dvsr_x) begin
         lane_in.rem = rem_sh - dvsr_x;
         lane_in.quo = {lane_i.quo[DVD_W-2:0], 1'b1};
      end else begin
         lane_in.rem = rem_sh;
         lane_in.quo = {lane_i.quo[DVD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

[sv/rotation_matrix_to_quaternion_core.sv]
// Rotation matrix to unit quaternion, pivoted method, Q1.16 fixed point.
// Pipeline: input stage, 18 square-root cells, divider setup, 35 divider
// cells per component, output register. One request per cycle, except
// that the whole pipeline holds while a result is stalled at the output.
// Synchronous active-high reset clears all valid flags; data is not reset.
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r00,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r01,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r02,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r10,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r11,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r12,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r20,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r21,
   input  wire signed [rmq_pkg::IN_W-1:0]      req_r22,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [rmq_pkg::IN_W-1:0]     rsp_quat_x,
   output logic signed [rmq_pkg::IN_W-1:0]     rsp_quat_y,
   output logic signed [rmq_pkg::IN_W-1:0]     rsp_quat_z,
   output logic signed [rmq_pkg::IN_W-1:0]     rsp_quat_w
);
   import rmq_pkg::*;

   logic adv;

   logic signed [CALC_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [CALC_W-1:0] trace, rad_s, one_s;
   logic [RAD_W-1:0]         rad_u;
   sq_side_type              side0;

   sq_lane_type sq_lane [SQ_STEPS+1];
   sq_lane_type sq_lane0_ff;
   sq_lane_type sq_lane0_in;
   logic        sq_v_ff   [SQ_STEPS+1];
   sq_side_type sq_sd_ff  [SQ_STEPS+1];

   dv_lane_type dv_lane [3][DIV_STEPS+1];
   dv_lane_type dv_lane0_ff [3];
   dv_lane_type dv_lane0_in [3];
   logic        dv_v_ff   [DIV_STEPS+1];
   dv_side_type dv_sd_ff  [DIV_STEPS+1];
   dv_side_type dv_sd_in;

   logic [ROOT_W-1:0]  root;
   logic [NUM_W-1:0]   mag [3];
   logic [ROOT_W:0]    piv_sum;
   logic [IN_W-1:0]    cmag [3];
   logic signed [IN_W-1:0] cval [3];
   logic signed [IN_W-1:0] pval;

   logic                   rsp_valid_ff;
   logic signed [IN_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [IN_W-1:0] qx_in, qy_in, qz_in, qw_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // front end: trace, pivot, radicand, numerators
   always_comb begin
      a00 = CALC_W'(req_r00); a01 = CALC_W'(req_r01); a02 = CALC_W'(req_r02);
      a10 = CALC_W'(req_r10); a11 = CALC_W'(req_r11); a12 = CALC_W'(req_r12);
      a20 = CALC_W'(req_r20); a21 = CALC_W'(req_r21); a22 = CALC_W'(req_r22);
      one_s = CALC_W'(signed'({1'b0, ONE_Q}));
      trace = a00 + a11 + a22;
      if (trace > 0) begin
         side0.sel = SEL_W;
      end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
         side0.sel = SEL_Z;
      end else if (a11 > a00) begin
         side0.sel = SEL_Y;
      end else begin
         side0.sel = SEL_X;
      end
      unique case (side0.sel)
         SEL_W: begin
            rad_s    = trace + one_s;
            side0.n0 = NUM_W'(a21 - a12);
            side0.n1 = NUM_W'(a02 - a20);
            side0.n2 = NUM_W'(a10 - a01);
         end
         SEL_X: begin
            rad_s    = a00 - a11 - a22 + one_s;
            side0.n0 = NUM_W'(a10 + a01);
            side0.n1 = NUM_W'(a20 + a02);
            side0.n2 = NUM_W'(a21 - a12);
         end
         SEL_Y: begin
            rad_s    = a11 - a22 - a00 + one_s;
            side0.n0 = NUM_W'(a21 + a12);
            side0.n1 = NUM_W'(a01 + a10);
            side0.n2 = NUM_W'(a02 - a20);
         end
         SEL_Z: begin
            rad_s    = a22 - a00 - a11 + one_s;
            side0.n0 = NUM_W'(a02 + a20);
            side0.n1 = NUM_W'(a12 + a21);
            side0.n2 = NUM_W'(a10 - a01);
         end
         default: begin
            rad_s    = one_s;
            side0.n0 = '0;
            side0.n1 = '0;
            side0.n2 = '0;
         end
      endcase
      rad_u = (rad_s > 0) ? rad_s[RAD_W-1:0] : RAD_W'(1);
      sq_lane0_in.rem  = '0;
      sq_lane0_in.root = '0;
      sq_lane0_in.rad  = SQ_IN_W'({rad_u, {FRAC_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_lane0_ff <= sq_lane0_in;
         sq_sd_ff[0] <= side0;
      end
   end

   assign sq_lane[0] = sq_lane0_ff;

   // square root chain
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock  (clock),
         .en     (adv),
         .lane_i (sq_lane[k]),
         .lane_o (sq_lane[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_sd_ff[k+1] <= sq_sd_ff[k];
         end
      end
   end

   // divider setup
   always_comb begin
      root      = sq_lane[SQ_STEPS].root;
      mag[0]    = sq_sd_ff[SQ_STEPS].n0[NUM_W-1] ? NUM_W'(-sq_sd_ff[SQ_STEPS].n0)
                                                 : NUM_W'(sq_sd_ff[SQ_STEPS].n0);
      mag[1]    = sq_sd_ff[SQ_STEPS].n1[NUM_W-1] ? NUM_W'(-sq_sd_ff[SQ_STEPS].n1)
                                                 : NUM_W'(sq_sd_ff[SQ_STEPS].n1);
      mag[2]    = sq_sd_ff[SQ_STEPS].n2[NUM_W-1] ? NUM_W'(-sq_sd_ff[SQ_STEPS].n2)
                                                 : NUM_W'(sq_sd_ff[SQ_STEPS].n2);
      piv_sum   = {1'b0, root} + (ROOT_W+1)'(1);
      dv_sd_in.sel   = sq_sd_ff[SQ_STEPS].sel;
      dv_sd_in.neg   = {sq_sd_ff[SQ_STEPS].n2[NUM_W-1], sq_sd_ff[SQ_STEPS].n1[NUM_W-1],
                        sq_sd_ff[SQ_STEPS].n0[NUM_W-1]};
      dv_sd_in.pivot = piv_sum[ROOT_W:1];
      for (int l = 0; l < 3; l++) begin
         dv_lane0_in[l].rem  = '0;
         dv_lane0_in[l].quo  = '0;
         dv_lane0_in[l].dvsr = {root, 1'b0};
         dv_lane0_in[l].dvd  = {mag[l], {FRAC_BITS{1'b0}}} + DVD_W'(root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_sd_ff[0] <= dv_sd_in;
         for (int l = 0; l < 3; l++) begin
            dv_lane0_ff[l] <= dv_lane0_in[l];
         end
      end
   end

   // divider chains, one per non-pivot component
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign dv_lane[l][0] = dv_lane0_ff[l];
      for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
         rmq_div_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .lane_i (dv_lane[l][k]),
            .lane_o (dv_lane[l][k+1])
         );
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dvs
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_sd_ff[k+1] <= dv_sd_ff[k];
         end
      end
   end

   // saturate and place components
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cmag[l] = (dv_lane[l][DIV_STEPS].quo > DVD_W'(ONE_Q)) ? ONE_Q
                 : dv_lane[l][DIV_STEPS].quo[IN_W-1:0];
         cval[l] = dv_sd_ff[DIV_STEPS].neg[l] ? signed'(-cmag[l]) : signed'(cmag[l]);
      end
      pval = signed'((dv_sd_ff[DIV_STEPS].pivot > PIV_W'(ONE_Q)) ? ONE_Q
                     : IN_W'(dv_sd_ff[DIV_STEPS].pivot));
      unique case (dv_sd_ff[DIV_STEPS].sel)
         SEL_W: begin
            qx_in = cval[0]; qy_in = cval[1]; qz_in = cval[2]; qw_in = pval;
         end
         SEL_X: begin
            qx_in = pval; qy_in = cval[0]; qz_in = cval[1]; qw_in = cval[2];
         end
         SEL_Y: begin
            qy_in = pval; qz_in = cval[0]; qx_in = cval[1]; qw_in = cval[2];
         end
         SEL_Z: begin
            qz_in = pval; qx_in = cval[0]; qy_in = cval[1]; qw_in = cval[2];
         end
         default: begin
            qx_in = '0; qy_in = '0; qz_in = '0; qw_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         qw_ff <= qw_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;
endmodule
`default_nettype wire
